// ----- src/lru_tile_cache_core_defines.svh -----
// Assertion macros used by the tile cache RTL.
`ifndef LRU_TILE_CACHE_CORE_DEFINES_SVH
`define LRU_TILE_CACHE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LTC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LTC_ASSERT(lbl, prop, msg)
`define LTC_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/ltc_pkg.sv -----
// Constants and types shared by the tile cache modules.
package ltc_pkg;

  localparam int ENTRIES     = 16;
  localparam int COORD_BITS  = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W       = IDX_W;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int TILE_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = 2 * TILE_W;
  localparam int OUT_FIELD_W = 1 + SLOT_W + 1 + 2 * TILE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(ENTRIES);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lookup_t;

  typedef struct packed {
    logic             hit;
    logic             evict;
    logic             write;
    logic [IDX_W-1:0] slot;
  } decision_t;

endpackage

// ----- src/ltc_tag_store.sv -----
// Coordinate storage with parallel tag compare and victim readout.
module ltc_tag_store
  import ltc_pkg::*;
(
  input  logic                  clk,
  input  logic                  go,
  input  coord_t                col,
  input  coord_t                row,
  input  logic [ENTRIES-1:0]    filled,
  input  decision_t             dec,
  output lookup_t               lookup,
  output coord_t                victim_col,
  output coord_t                victim_row
);

  coord_t             col_r [ENTRIES];
  coord_t             row_r [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   first_idx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = filled[i] && (col_r[i] == col) && (row_r[i] == row);
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign lookup.hit = |match;
  assign lookup.idx = first_idx;

  assign victim_col = col_r[dec.slot];
  assign victim_row = row_r[dec.slot];

  always_ff @(posedge clk) begin
    if (go && dec.write) begin
      col_r[dec.slot] <= col;
      row_r[dec.slot] <= row;
    end
  end

endmodule

// ----- src/ltc_age_ctrl.sv -----
// Recency ranks, fill count and the hit, fill or evict decision.
`include "lru_tile_cache_core_defines.svh"
module ltc_age_ctrl
  import ltc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  lookup_t            lookup,
  output logic [ENTRIES-1:0] filled,
  output decision_t          dec
);

  logic [AGE_W-1:0]   age_r   [ENTRIES];
  logic [AGE_W-1:0]   age_nxt [ENTRIES];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [ENTRIES-1:0] oldest;
  logic [IDX_W-1:0]   victim_idx;
  logic [AGE_W-1:0]   hit_age;
  logic               full;

  assign full = (count_r == CNT_FULL);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      filled[i] = CNT_W'(i) < count_r;
      oldest[i] = age_r[i] == AGE_OLDEST;
    end
  end

  always_comb begin
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (oldest[i]) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    dec.hit   = lookup.hit;
    dec.evict = 1'b0;
    dec.write = 1'b0;
    dec.slot  = lookup.idx;
    if (!lookup.hit) begin
      dec.write = 1'b1;
      if (full) begin
        dec.evict = 1'b1;
        dec.slot  = victim_idx;
      end else begin
        dec.slot = count_r[IDX_W-1:0];
      end
    end
  end

  assign hit_age = age_r[lookup.idx];

  // On a hit only entries younger than the hit entry age; on a miss all other filled ones do.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      if (go) begin
        if (IDX_W'(i) == dec.slot) begin
          age_nxt[i] = '0;
        end else if (filled[i] && (!dec.hit || (age_r[i] < hit_age))) begin
          age_nxt[i] = age_r[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (go && !dec.hit && !full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  `LTC_ASSERT(a_full_one_oldest, full |-> $onehot(oldest), "full cache lacks a unique oldest entry")
  `LTC_NEVER(a_count_range, count_r > CNT_FULL, "fill count beyond capacity")
  `LTC_ASSERT(a_slot_newest, go |=> (age_r[$past(dec.slot)] == '0), "used slot not made newest")
  `LTC_ASSERT(a_fill_count, (go && !dec.hit && !full) |=> (count_r == $past(count_r) + 1'b1), "fill count did not advance")
  `LTC_NEVER(a_hit_unfilled, lookup.hit && !filled[lookup.idx], "hit on an unfilled slot")

endmodule

// ----- src/lru_tile_cache_core.sv -----
// Top level of the tile cache tag and replacement controller.
//
//   Channel   Direction   Payload (lowest bit first)
//   in_*      input       tile_col, tile_row
//   out_*     output      hit, slot, evicted, victim_col, victim_row
//
// One request is taken per cycle while the output is not stalled; its result passes through a
// stage register and then a result register before it is presented.
// The tag compare, the recency update and the entry write all happen in the cycle
// between those two registers, so the next request sees the updated state.
// Reset clears the fill count, the recency ranks and both valid flags.
// A stalled output holds the stage register, and the input is stalled only once both are full.
module lru_tile_cache_core
  import ltc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // tile_col, tile_row
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // hit, slot, evicted, victim_col, victim_row, pad
);

  logic                   stage_valid_r;
  coord_t                 stage_col_r;
  coord_t                 stage_row_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic                   go;
  logic                   in_fire;
  logic [ENTRIES-1:0]     filled;
  lookup_t                lookup;
  decision_t              dec;
  coord_t                 victim_col;
  coord_t                 victim_row;
  logic [TILE_W-1:0]      vcol_field;
  logic [TILE_W-1:0]      vrow_field;

  assign go        = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || go;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        stage_valid_r <= 1'b1;
      end else if (go) begin
        stage_valid_r <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_col_r <= COORD_BITS'(in_tdata[TILE_W-1:0]);
      stage_row_r <= COORD_BITS'(in_tdata[2*TILE_W-1:TILE_W]);
    end
    if (go) begin
      out_data_r <= out_data_nxt;
    end
  end

  ltc_tag_store u_tag_store (
    .clk        (clk),
    .go         (go),
    .col        (stage_col_r),
    .row        (stage_row_r),
    .filled     (filled),
    .dec        (dec),
    .lookup     (lookup),
    .victim_col (victim_col),
    .victim_row (victim_row)
  );

  ltc_age_ctrl u_age_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .lookup (lookup),
    .filled (filled),
    .dec    (dec)
  );

  assign vcol_field = dec.evict ? TILE_W'(victim_col) : '0;
  assign vrow_field = dec.evict ? TILE_W'(victim_row) : '0;

  assign out_data_nxt = {{OUT_PAD_W{1'b0}}, vrow_field, vcol_field, dec.evict,
                         SLOT_W'(dec.slot), dec.hit};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
